/* src/gtm_pkg.sv */
// Shared types and constants for the gradient threshold mask block.
// No dependencies; imported by every module of the block.
package gtm_pkg;

  // Field and port widths
  localparam int PIX_W    = 8;
  localparam int G2_W     = 17;
  localparam int THR_W    = 17;
  localparam int TSQ_W    = 2 * THR_W;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 13;
  localparam int ROW_W    = 12;
  localparam int ADDR_W   = 4;
  localparam int APB_W    = 32;
  localparam int OUT_W    = 32;

  // Defaults and limits
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FIFO_DEPTH    = 8;
  localparam int NUM_CELLS     = 2;
  localparam int MIN_DIM       = 3;
  localparam int MAX_HEIGHT    = 4096;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0]   THR_RST    = 17'd5;

  localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

  // Register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2,
    REG_SPARE  = 2'd3
  } reg_idx_t;

  // One window column: rows above, center and below
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  // Per-request control carried down the pipeline
  typedef struct packed {
    logic r0_valid;   // request yields a first result
    logic interior;   // first result uses the computed gradient
    logic eof;        // first result closes the frame
    logic two;        // request yields a second, right-border result
  } item_ctl_t;

  // Queue entry: the results of one request
  typedef struct packed {
    logic            low;
    logic [G2_W-1:0] g2;
    logic            eof;
    logic            two;
  } entry_t;

  // One result on the master side
  typedef struct packed {
    logic [PIX_W-1:0] mask;
    logic [G2_W-1:0]  g2;
    logic             last;
    logic             eof;
  } result_t;

endpackage

/* src/gtm_line_buffer.sv */
// One row line buffer: single write port, single registered read port.
// Depends on gtm_pkg for the pixel width.
module gtm_line_buffer #(
  parameter int DEPTH = gtm_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [gtm_pkg::PIX_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [gtm_pkg::PIX_W-1:0] wr_data
);
  import gtm_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/gtm_cell.sv */
// Window cell: holds one pixel column and passes it to the next cell.
// Depends on gtm_pkg for the column type.
module gtm_cell (
  input  logic             clk,
  input  logic             shift,
  input  gtm_pkg::column_t col_in,
  output gtm_pkg::column_t col_out
);
  import gtm_pkg::*;

  // Take the neighbor's column on every pixel
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

/* src/gtm_result_fifo.sv */
// Result queue: one entry per request, split into one or two results.
// Depends on gtm_pkg for entry and result types.
module gtm_result_fifo #(
  parameter int DEPTH = gtm_pkg::FIFO_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gtm_pkg::entry_t   push_entry,
  output logic [LW-1:0]     level,
  output logic              out_valid,
  input  logic              out_ready,
  output gtm_pkg::result_t  out_result
);
  import gtm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic          sub;
  entry_t        head;
  logic          out_take;
  logic          pop;

  assign head      = mem[rptr];
  assign out_valid = (level != '0);
  assign out_take  = out_valid & out_ready;
  assign pop       = out_take & (sub | ~head.two);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  // Pointers, fill level and result index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
      sub   <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      level <= level + LW'(push) - LW'(pop);
      if (out_take) begin
        sub <= ~pop;
      end
    end
  end

  // Second result of a request is the zero-gradient right border
  always_comb begin
    if (sub) begin
      out_result.mask = MASK_ON;
      out_result.g2   = '0;
      out_result.last = 1'b1;
      out_result.eof  = 1'b0;
    end else begin
      out_result.mask = head.low ? MASK_ON : MASK_OFF;
      out_result.g2   = head.g2;
      out_result.last = ~head.two;
      out_result.eof  = head.eof;
    end
  end

endmodule

/* src/gradient_threshold_mask.sv */
// Top level: stream ports, config registers, raster counters, line buffers,
// window cell chain, squared-gradient pipeline and result queue.
// Depends on gtm_pkg, gtm_line_buffer, gtm_cell, gtm_result_fifo.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+---------------------------------
//  s_*      | in  | s_tvalid / s_tready         | tdata: pixel_value; tuser: action
//  m_*      | out | m_tvalid / m_tready         | tdata: mask, g2; tlast; tuser: eof
//  apb      | in  | psel, penable, pwrite       | paddr, pwdata, prdata; pready = 1
//
// One request is accepted per cycle while s_tready is high; its results pass
// the pipeline stages and then an 8-entry queue. The frame's last pixel gives
// two results from a single queue entry. s_tready falls only when the queue
// plus the three pipeline stages would overflow, which happens only under
// m_tready stalls. Synchronous reset clears counters, pipeline valid bits and
// the queue; line buffers are not cleared.
module gradient_threshold_mask #(
  parameter int MAX_WIDTH = gtm_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [gtm_pkg::PIX_W-1:0] s_tdata,   // [7:0] pixel_value
  input  logic                      s_tuser,   // [0] action (1 = drain)
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [gtm_pkg::OUT_W-1:0] m_tdata,   // [7:0] mask_value, [24:8] gradient_squared
  output logic                      m_tlast,   // last_of_item
  output logic                      m_tuser,   // [0] end_of_frame
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gtm_pkg::ADDR_W-1:0] paddr,
  input  logic [gtm_pkg::APB_W-1:0] pwdata,
  output logic [gtm_pkg::APB_W-1:0] prdata,
  output logic                      pready
);
  import gtm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  // Config registers
  logic [IMG_W_W-1:0] width_raw;
  logic [IMG_H_W-1:0] height_raw;
  logic [THR_W-1:0]   thr;
  logic [TSQ_W-1:0]   tsq;
  reg_idx_t           reg_idx;
  logic               cfg_we;
  logic [WW-1:0]      w;
  logic [IMG_H_W-1:0] h;

  // Raster state
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    dcnt;
  logic             draining;
  logic [CW-1:0]    cur_c;
  logic [ROW_W-1:0] cur_r;
  logic             col_last;
  logic             row_last;
  logic             drain_eof;
  logic             in_acc;
  logic             is_drain;
  item_ctl_t        ctl0;

  // Pipeline
  logic             v1, v2, v3;
  item_ctl_t        ctl1, ctl2, ctl3;
  logic             isp1;
  logic [CW-1:0]    c1;
  logic [PIX_W-1:0] pix1;
  logic [PIX_W-1:0] mid_rd;
  logic [PIX_W-1:0] top_rd;
  logic             shift;
  column_t          tap [NUM_CELLS+1];
  logic [PIX_W-1:0] adx, ady;
  logic [PIX_W-1:0] adx_d, ady_d;
  logic [2*PIX_W-1:0] sx, sy;
  logic [G2_W-1:0]  g2;
  logic             push;
  entry_t           push_entry;
  logic [LW-1:0]    level;
  logic [LW:0]      occ;
  result_t          out_result;

  // Config port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= WIDTH_RST;
      height_raw <= HEIGHT_RST;
      thr        <= THR_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WIDTH:  width_raw  <= pwdata[IMG_W_W-1:0];
        REG_HEIGHT: height_raw <= pwdata[IMG_H_W-1:0];
        REG_THRESH: thr        <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_W'(width_raw);
      REG_HEIGHT: prdata = APB_W'(height_raw);
      REG_THRESH: prdata = APB_W'(thr);
      default:    prdata = '0;
    endcase
  end

  // Squared threshold, refreshed every cycle
  always_ff @(posedge clk) begin
    tsq <= TSQ_W'(thr) * TSQ_W'(thr);
  end

  // Effective frame size
  always_comb begin
    if (width_raw < IMG_W_W'(MIN_DIM)) begin
      w = WW'(MIN_DIM);
    end else if (32'(width_raw) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_raw);
    end
    if (height_raw < IMG_H_W'(MIN_DIM)) begin
      h = IMG_H_W'(MIN_DIM);
    end else if (height_raw > IMG_H_W'(MAX_HEIGHT)) begin
      h = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h = height_raw;
    end
  end

  // Position of the incoming request; a pixel after a drain starts a frame
  assign in_acc    = s_tvalid & s_tready;
  assign is_drain  = s_tuser;
  assign cur_c     = draining ? '0 : col;
  assign cur_r     = draining ? '0 : row;
  assign col_last  = (WW'(cur_c) + WW'(1)) == w;
  assign row_last  = (IMG_H_W'(cur_r) + IMG_H_W'(1)) == h;
  assign drain_eof = (WW'(dcnt) + WW'(1)) >= w;

  // Which results this request causes
  always_comb begin
    ctl0 = '0;
    if (is_drain) begin
      ctl0.r0_valid = draining;
      ctl0.eof      = drain_eof;
    end else begin
      ctl0.r0_valid = (cur_c == '0) ? (cur_r >= ROW_W'(2)) : (cur_r >= ROW_W'(1));
      ctl0.interior = (cur_c >= CW'(2)) && (cur_r >= ROW_W'(2));
      ctl0.two      = col_last & row_last;
    end
  end

  // Raster and drain counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      dcnt     <= '0;
      draining <= 1'b0;
    end else if (cfg_we && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT)) begin
      col      <= '0;
      row      <= '0;
      dcnt     <= '0;
      draining <= 1'b0;
    end else if (in_acc) begin
      if (is_drain) begin
        if (draining) begin
          dcnt <= dcnt + 1'b1;
          if (drain_eof) begin
            draining <= 1'b0;
          end
        end
      end else begin
        if (col_last) begin
          col <= '0;
          row <= row_last ? '0 : cur_r + 1'b1;
        end else begin
          col <= cur_c + 1'b1;
          row <= cur_r;
        end
        draining <= ctl0.two;
        dcnt     <= '0;
      end
    end
  end

  // Stage 1: line buffer read data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    ctl1 <= ctl0;
    isp1 <= ~is_drain;
    c1   <= cur_c;
    pix1 <= s_tdata;
  end

  assign shift = v1 & isp1;

  // Above row takes the old center row; center row takes the new pixel
  gtm_line_buffer #(.DEPTH(MAX_WIDTH), .AW(CW)) u_above (
    .clk     (clk),
    .rd_en   (in_acc & ~is_drain),
    .rd_addr (cur_c),
    .rd_data (top_rd),
    .wr_en   (shift),
    .wr_addr (c1),
    .wr_data (mid_rd)
  );

  gtm_line_buffer #(.DEPTH(MAX_WIDTH), .AW(CW)) u_center (
    .clk     (clk),
    .rd_en   (in_acc & ~is_drain),
    .rd_addr (cur_c),
    .rd_data (mid_rd),
    .wr_en   (shift),
    .wr_addr (c1),
    .wr_data (pix1)
  );

  // Window chain: tap 0 is the current column, tap i the column i pixels back
  always_comb begin
    tap[0].top = top_rd;
    tap[0].mid = mid_rd;
    tap[0].bot = pix1;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gtm_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (tap[i]),
      .col_out (tap[i+1])
    );
  end

  // Central difference magnitudes: |right - left|, |below - above|
  assign adx = (tap[0].mid >= tap[2].mid) ? tap[0].mid - tap[2].mid
                                          : tap[2].mid - tap[0].mid;
  assign ady = (tap[1].bot >= tap[1].top) ? tap[1].bot - tap[1].top
                                          : tap[1].top - tap[1].bot;

  // Stage 2: difference magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ctl2  <= ctl1;
    adx_d <= adx;
    ady_d <= ady;
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    ctl3 <= ctl2;
    sx   <= adx_d * adx_d;
    sy   <= ady_d * ady_d;
  end

  // Sum and threshold compare: g2 * 2^16 <= t^2  <=>  g2 <= t^2 >> 16
  assign g2 = ctl3.interior ? G2_W'(sx) + G2_W'(sy) : '0;

  always_comb begin
    push_entry.low = {1'b0, g2} <= tsq[TSQ_W-1:16];
    push_entry.g2  = g2;
    push_entry.eof = ctl3.eof;
    push_entry.two = ctl3.two;
  end

  assign push = v3 & ctl3.r0_valid;

  gtm_result_fifo #(.DEPTH(FIFO_DEPTH), .LW(LW)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .level      (level),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  // Room for every request still in flight
  assign occ      = {1'b0, level} + (LW+1)'(v1) + (LW+1)'(v2) + (LW+1)'(v3);
  assign s_tready = occ < (LW+1)'(FIFO_DEPTH);

  // Master side packing
  assign m_tdata = {(OUT_W - G2_W - PIX_W)'(0), out_result.g2, out_result.mask};
  assign m_tlast = out_result.last;
  assign m_tuser = out_result.eof;

endmodule

/* tb/tb_gradient_threshold_mask.sv */
// Self-checking testbench for gradient_threshold_mask: stream pixels and
// drains in, check mask and squared gradient out against an in-bench predictor.
// Depends on gtm_pkg and the gradient_threshold_mask RTL only.
module tb_gradient_threshold_mask;
  timeunit 1ns;
  timeprecision 1ps;

  import gtm_pkg::*;

  localparam int STALL_PCT     = 18;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int RANDOM_ITEMS  = 250;

  // Directed 3x3 frames: interior pixel sees full-scale and boundary gradients
  localparam logic [PIX_W-1:0] FRAME_FULL [9] = '{0, 255, 255, 0, 128, 255, 255, 0, 0};
  localparam logic [PIX_W-1:0] FRAME_EDGE [9] = '{7, 10, 9, 20, 99, 23, 1, 14, 2};

  // Predicts mask results from accepted requests and checks the output stream
  class mask_scoreboard;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [THR_W-1:0]   thresh_reg;
    logic [PIX_W-1:0]   above_row  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   center_row [MAX_WIDTH_DEF];
    int      prev_pixel, row, col, drain_count, mid_d1, mid_d2, top_d1;
    bit      draining;
    result_t masks_due[$];
    int      errors;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      thresh_reg = THR_RST;
      foreach (above_row[i]) begin
        above_row[i]  = '0;
        center_row[i] = '0;
      end
      prev_pixel = 0;
      mid_d1     = 0;
      mid_d2     = 0;
      top_d1     = 0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      row         = 0;
      col         = 0;
      drain_count = 0;
      draining    = 1'b0;
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function int pending();
      return masks_due.size();
    endfunction

    function void write_register(reg_idx_t idx, logic [APB_W-1:0] value);
      case (idx)
        REG_WIDTH: begin
          width_reg = value[IMG_W_W-1:0];
          restart();
        end
        REG_HEIGHT: begin
          height_reg = value[IMG_H_W-1:0];
          restart();
        end
        REG_THRESH: begin
          thresh_reg = value[THR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Squared-domain compare: g2 * 2^16 <= t * t
    function void push_mask(int g2, bit eof);
      result_t r;
      longint unsigned lhs, t;
      lhs    = longint'(g2) << 16;
      t      = thresh_reg;
      r.mask = (lhs <= t * t) ? MASK_ON : MASK_OFF;
      r.g2   = G2_W'(g2);
      r.last = 1'b0;
      r.eof  = eof;
      masks_due.push_back(r);
    endfunction

    function void predict_masks(bit drain, logic [PIX_W-1:0] pix);
      int w, h, c, r, n, g2, dx, dy;
      int mid, top;
      w = eff_width();
      h = eff_height();
      n = 0;
      if (drain) begin
        if (!draining) return;
        push_mask(0, drain_count >= w - 1);
        masks_due[masks_due.size() - 1].last = 1'b1;
        if (drain_count >= w - 1) draining = 1'b0;
        drain_count = (drain_count + 1) & 32'h3FF;
        return;
      end
      // a pixel cuts any pending drain short and opens a new frame
      if (draining) restart();
      c = col;
      r = row;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      mid = center_row[c];
      top = above_row[c];
      if (c == 0) begin
        // right-border result of two rows up
        if (r >= 2) begin
          push_mask(0, 1'b0);
          n++;
        end
      end else if (r >= 1) begin
        g2 = 0;
        if (r - 1 >= 1 && r - 1 <= h - 2 && c - 1 >= 1 && c - 1 <= w - 2) begin
          dx = mid - mid_d2;
          dy = prev_pixel - top_d1;
          g2 = dx * dx + dy * dy;
        end
        push_mask(g2, 1'b0);
        n++;
      end
      // last pixel of the frame: extra right-border result, then drain
      if (r == h - 1 && c == w - 1) begin
        push_mask(0, 1'b0);
        n++;
        draining    = 1'b1;
        drain_count = 0;
      end
      above_row[c]  = PIX_W'(mid);
      center_row[c] = pix;
      mid_d2        = mid_d1;
      mid_d1        = mid;
      top_d1        = top;
      prev_pixel    = pix;
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
      if (n > 0) masks_due[masks_due.size() - 1].last = 1'b1;
    endfunction

    function void compare_mask(result_t got);
      result_t want;
      if (masks_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing due: mask %0d g2 %0d last %0b eof %0b",
                   $time, got.mask, got.g2, got.last, got.eof);
        return;
      end
      want = masks_due.pop_front();
      if (got.mask !== want.mask || got.g2 !== want.g2 ||
          got.last !== want.last || got.eof !== want.eof) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp/got mask %0d/%0d g2 %0d/%0d last %0b/%0b eof %0b/%0b",
                   $time, want.mask, got.mask, want.g2, got.g2,
                   want.last, got.last, want.eof, got.eof);
      end
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [PIX_W-1:0]    s_tdata  = '0;  // [7:0] pixel_value
  logic                s_tuser  = 1'b0; // [0] action (1 = drain)
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;        // [7:0] mask_value, [24:8] gradient_squared
  logic                m_tlast;        // last_of_item
  logic                m_tuser;        // [0] end_of_frame
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [APB_W-1:0]    pwdata   = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  mask_scoreboard masks;
  bit             no_gaps = 1'b0;
  int             stream_items = 0;
  int             quiet_cycles = 0;

  gradient_threshold_mask dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One request on the slave side; gaps before it at random
  task automatic send_request(bit drain, logic [PIX_W-1:0] pix);
    while (!no_gaps && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= drain;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    masks.predict_masks(drain, pix);
  endtask

  // Pixels with one of three textures; a stray drain now and then
  task automatic send_pixels(int count);
    int style;
    int base;
    int p;
    style = $urandom_range(0, 2);
    base  = $urandom_range(0, 255);
    repeat (count) begin
      if ($urandom_range(0, 99) < 4) send_request(1'b1, PIX_W'($urandom));
      case (style)
        0: p = $urandom_range(0, 255);
        1: begin
          p = base + $urandom_range(0, 6) - 3;
          if (p < 0) p = 0;
          if (p > 255) p = 255;
        end
        default: p = $urandom_range(0, 1) ? 255 : 0;
      endcase
      send_request(1'b0, PIX_W'(p));
      stream_items++;
    end
  endtask

  task automatic send_drains(int count);
    repeat (count) begin
      send_request(1'b1, PIX_W'($urandom));
      stream_items++;
    end
  endtask

  // Wait until every due result is out and the pipeline has emptied
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (masks.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; register lands when pready is seen
  task automatic apb_write(reg_idx_t idx, logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    masks.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [APB_W-1:0] with_junk(logic [APB_W-1:0] value, int bits);
    if ($urandom_range(0, 4) == 0) return value | ($urandom << bits);
    return value;
  endfunction

  function automatic logic [APB_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 2);
    if (r < 20) return $urandom_range(13, 40);
    return $urandom_range(3, 12);
  endfunction

  function automatic logic [APB_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 2);
    if (r < 12) return $urandom_range(MAX_HEIGHT, 8191);
    return $urandom_range(3, 6);
  endfunction

  function automatic logic [APB_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return APB_W'(THR_RST);
      2: return $urandom_range(0, 3000);
      3: return $urandom_range(0, 92416);
      4: return 92416;
      default: return $urandom_range(92417, 131071);
    endcase
  endfunction

  // Result side: accept and check, random back-pressure
  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.mask = m_tdata[PIX_W-1:0];
        got.g2   = m_tdata[PIX_W +: G2_W];
        got.last = m_tlast;
        got.eof  = m_tuser;
        masks.compare_mask(got);
      end
      m_tready <= no_gaps || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("gradient_threshold_mask test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int w, h, pick;
    masks = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: drain with nothing pending at reset defaults
    send_request(1'b1, 8'hA5);
    settle_block();
    apb_write(REG_WIDTH, 3);
    apb_write(REG_HEIGHT, 3);
    // full-scale gradient, then three last-row drains and one with nothing left
    foreach (FRAME_FULL[i]) send_request(1'b0, FRAME_FULL[i]);
    repeat (4) send_request(1'b1, PIX_W'($urandom));
    settle_block();
    // threshold 5.0 against g2 = 25 exactly at the boundary
    apb_write(REG_THRESH, 1280);
    foreach (FRAME_EDGE[i]) send_request(1'b0, FRAME_EDGE[i]);
    repeat (2) send_request(1'b1, PIX_W'($urandom));
    // pixel while drain pending starts a new frame
    send_request(1'b0, 8'h00);
    settle_block();
    apb_write(REG_SPARE, 32'hFFFF_FFFF);

    // Widest rows: width and height both clamped from above
    apb_write(REG_WIDTH, 2047);
    apb_write(REG_HEIGHT, 8191);
    apb_write(REG_THRESH, 0);
    send_pixels(MAX_WIDTH_DEF + 6);

    // Random phases: mostly whole frames with drains, some cut short
    stream_items = 0;
    while (stream_items < RANDOM_ITEMS) begin
      settle_block();
      if ($urandom_range(0, 99) < 35) apb_write(REG_WIDTH, with_junk(pick_width(), IMG_W_W));
      if ($urandom_range(0, 99) < 35)
        apb_write(REG_HEIGHT, with_junk(pick_height(), IMG_H_W));
      if ($urandom_range(0, 99) < 50)
        apb_write(REG_THRESH, with_junk(pick_threshold(), THR_W));
      if ($urandom_range(0, 99) < 5) apb_write(REG_SPARE, $urandom);
      no_gaps = (stream_items >= 80 && stream_items < 180);
      w    = masks.eff_width();
      h    = masks.eff_height();
      pick = $urandom_range(0, 9);
      if (w * h > 400) pick = 9;
      if (pick <= 6) begin
        repeat ($urandom_range(1, 2)) begin
          send_pixels(w * h);
          send_drains(w + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
        end
      end else if (pick == 7) begin
        send_pixels(w * h);
        send_drains($urandom_range(0, w - 1));
      end else begin
        send_pixels($urandom_range(1, (w * h > 300) ? 300 : w * h - 1));
      end
    end
    no_gaps = 1'b0;

    // Drain out and look for stray results
    settle_block();
    if (masks.errors == 0 && masks.pending() == 0)
      $display("gradient_threshold_mask test passed");
    else
      $display("gradient_threshold_mask test failed");
    $finish;
  end

endmodule

/* gradient_threshold_mask.f */
src/gtm_pkg.sv
src/gtm_line_buffer.sv
src/gtm_cell.sv
src/gtm_result_fifo.sv
src/gradient_threshold_mask.sv
tb/tb_gradient_threshold_mask.sv
